// ===== sv/tpaf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpaf_pkg
// shared types and constants of the triac phase-angle firing controller
// ----------------------------------------------------------------------------
package tpaf_pkg;

	localparam int TICK_BITS_DEF = 12;
	localparam int REG_W         = 12;
	localparam int CMP_W         = 18;   // holds elapsed time at the widest tick setting
	localparam int LEN_W         = 17;   // delay length before saturation

	localparam int EDGES_PER_TICK = 5;
	localparam int FIVE_TOP       = 9;

	localparam logic [REG_W-1:0] DELAY_MAX_RST     = 12'd810;
	localparam logic [REG_W-1:0] FIRE_DURATION_RST = 12'd0;
	localparam logic             INDUCTIVE_RST     = 1'b0;
	localparam logic [REG_W-1:0] RETRIGGER_GAP_RST = 12'd20;

	// register indexes
	localparam logic [1:0] CFG_DELAY_MAX     = 2'd0;
	localparam logic [1:0] CFG_FIRE_DURATION = 2'd1;
	localparam logic [1:0] CFG_INDUCTIVE     = 2'd2;
	localparam logic [1:0] CFG_RETRIGGER_GAP = 2'd3;

	// input kinds
	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_EDGE = 1'b1;

	typedef struct packed {
		logic [REG_W-1:0] delay_max;
		logic [REG_W-1:0] fire_duration;
		logic             inductive_load;
		logic [REG_W-1:0] retrigger_gap;
	} cfg_t;

	typedef struct packed {
		logic [3:0] five_cycle_count;
		logic       five_cycle_tick;
		logic       delay_running;
		logic       fire;
	} res_t;

endpackage

`default_nettype wire

// ===== sv/tpaf_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpaf_cfg
// configuration register file, write only
// ----------------------------------------------------------------------------
module tpaf_cfg
	import tpaf_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [REG_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delay_max      <= DELAY_MAX_RST;
			cfg_q.fire_duration  <= FIRE_DURATION_RST;
			cfg_q.inductive_load <= INDUCTIVE_RST;
			cfg_q.retrigger_gap  <= RETRIGGER_GAP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DELAY_MAX:     cfg_q.delay_max      <= cfg_wdata;
				CFG_FIRE_DURATION: cfg_q.fire_duration  <= cfg_wdata;
				CFG_INDUCTIVE:     cfg_q.inductive_load <= cfg_wdata[0];
				CFG_RETRIGGER_GAP: cfg_q.retrigger_gap  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== sv/tpaf_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpaf_core
// remaining-delay, elapsed, phase and five_cycle_count counters and their combinational update
// ----------------------------------------------------------------------------
module tpaf_core
	import tpaf_pkg::*;
#(
	parameter int TICK_BITS = TICK_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic step,
	input  wire logic action,
	input  wire logic line_level,
	input  wire cfg_t cfg,
	output res_t      res
);

	localparam logic [LEN_W-1:0] REMAIN_MAX = LEN_W'((1 << TICK_BITS) - 1);

	logic [TICK_BITS-1:0] remain_q,  remain_d;
	logic [TICK_BITS+1:0] elapsed_q, elapsed_d;
	logic                 running_q, running_d;
	logic [2:0]           phase_q,   phase_d;
	logic [3:0]           five_q,    five_d;

	logic [TICK_BITS-1:0] remain_dec;
	logic [TICK_BITS+1:0] elapsed_inc;
	logic [REG_W-1:0]     dur;
	logic [TICK_BITS-1:0] gap_len;
	logic [TICK_BITS-1:0] edge_len;
	logic                 fire;
	logic                 tick5;

	// floor at one, saturate at the remaining-ticks width
	function automatic logic [TICK_BITS-1:0] sat_len(input logic [REG_W-1:0] len);
		logic [LEN_W-1:0] w;
		w = LEN_W'(len);
		if (w == '0)
			w = LEN_W'(1);
		if (w > REMAIN_MAX)
			w = REMAIN_MAX;
		return w[TICK_BITS-1:0];
	endfunction

	always_comb begin
		remain_dec  = (remain_q != '0) ? remain_q - 1'b1 : '0;
		elapsed_inc = (elapsed_q != '1) ? elapsed_q + 1'b1 : elapsed_q;
		dur         = (cfg.fire_duration < cfg.delay_max) ? cfg.fire_duration : cfg.delay_max;
		gap_len     = sat_len(cfg.retrigger_gap);
		edge_len    = sat_len(cfg.delay_max - dur);

		remain_d  = remain_q;
		elapsed_d = elapsed_q;
		running_d = running_q;
		phase_d   = phase_q;
		five_d    = five_q;
		fire      = 1'b0;
		tick5     = 1'b0;

		if (action == ACT_TICK) begin
			if (running_q) begin
				remain_d  = remain_dec;
				elapsed_d = elapsed_inc;
				if (remain_dec == '0) begin
					fire = 1'b1;
					if ((CMP_W'(elapsed_inc) >= CMP_W'(cfg.delay_max)) || !cfg.inductive_load) begin
						running_d = 1'b0;
					end else begin
						remain_d  = gap_len;
						running_d = 1'b1;
					end
				end
			end
		end else if (!line_level) begin
			running_d = 1'b0;
			remain_d  = '0;
		end else begin
			elapsed_d = '0;
			if (dur != '0) begin
				remain_d  = edge_len;
				running_d = 1'b1;
			end
			if (phase_q == 3'(EDGES_PER_TICK - 1)) begin
				tick5   = 1'b1;
				phase_d = '0;
				five_d  = (five_q == 4'(FIVE_TOP)) ? '0 : five_q + 1'b1;
			end else begin
				phase_d = phase_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remain_q  <= '0;
			elapsed_q <= '0;
			running_q <= 1'b0;
			phase_q   <= '0;
			five_q    <= '0;
		end else if (step) begin
			remain_q  <= remain_d;
			elapsed_q <= elapsed_d;
			running_q <= running_d;
			phase_q   <= phase_d;
			five_q    <= five_d;
		end
	end

	assign res.fire             = fire;
	assign res.delay_running    = running_d;
	assign res.five_cycle_tick  = tick5;
	assign res.five_cycle_count = five_d;

endmodule

`default_nettype wire

// ===== sv/triac_phase_angle_firing_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// triac_phase_angle_firing_top
// phase-angle triac firing controller with retrigger for inductive loads
// ----------------------------------------------------------------------------
// path: input word to result word through the input register, then the result register
// throughput: one word per cycle while the result register is free, the core updating its counters per word
// the result register frees as it is taken, so input and output can move together
// reset: arst_n clears all counters and valid flags and loads register defaults
// ----------------------------------------------------------------------------
module triac_phase_angle_firing_top
	import tpaf_pkg::*;
#(
	parameter int TICK_BITS = TICK_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// configuration write port
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [REG_W-1:0] cfg_wdata,
	// input words
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [7:0]       s_tdata,   // [0] line_level, rest zero
	input  wire logic             s_tuser,   // [0] action: tick or zero-cross edge
	// result words
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [7:0]            m_tdata    // [0] fire, [1] delay_running,
	                                         // [2] five_cycle_tick, [6:3] five_cycle_count
);

	cfg_t cfg;
	res_t res;

	// input register
	logic valid_s1;
	logic action_s1;
	logic level_s1;

	// result register
	logic m_valid_q;
	res_t res_q;

	logic out_free;
	logic advance;

	// result register is free when empty or being taken this cycle
	assign out_free = !m_valid_q || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	tpaf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// state moves only when the held word passes into the result register
	tpaf_core #(
		.TICK_BITS (TICK_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.action     (action_s1),
		.line_level (level_s1),
		.cfg        (cfg),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			action_s1 <= s_tuser;
			level_s1  <= s_tdata[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, res_q.five_cycle_count, res_q.five_cycle_tick,
	                   res_q.delay_running, res_q.fire};

endmodule

`default_nettype wire
